// File: rtl/lgcs_pkg.sv
// ----------------------------------------------------------------------------
// lgcs_pkg
// Shared types and constants for the single-word cofactor step block.
// ----------------------------------------------------------------------------
package lgcs_pkg;

  // Width of the result and operand ports, fixed by the interface.
  localparam int OUT_BITS = 64;

  // Control beat from the sequencer to the shared divide/accumulate unit.
  typedef struct packed {
    logic load;  // Start a new division: take dividend, clear remainder and sums.
    logic step;  // Retire one quotient bit.
  } lgcs_ctl_t;

endpackage

// File: rtl/lgcs_div_mac.sv
// ----------------------------------------------------------------------------
// lgcs_div_mac
// Bit-serial restoring divider with two multiply-accumulate lanes fed by the
// quotient bits, one quotient bit per step.
// ----------------------------------------------------------------------------
module lgcs_div_mac
  import lgcs_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic                 clk,
  input  lgcs_ctl_t            ctl,
  input  logic [WORD_BITS-1:0] dividend,
  input  logic [WORD_BITS-1:0] divisor,
  input  logic [WORD_BITS-1:0] mul_u,
  input  logic [WORD_BITS-1:0] mul_v,
  output logic [WORD_BITS-1:0] rem,
  output logic [WORD_BITS-1:0] acc_u,
  output logic [WORD_BITS-1:0] acc_v
);

  logic [WORD_BITS-1:0] dvd;
  logic [WORD_BITS:0]   rem_sh;
  logic [WORD_BITS+1:0] trial;
  logic                 qbit;
  logic [WORD_BITS-1:0] rem_next;
  logic [WORD_BITS-1:0] acc_u_next;
  logic [WORD_BITS-1:0] acc_v_next;

  always_comb begin
    rem_sh = {rem, dvd[WORD_BITS-1]};
    trial  = {1'b0, rem_sh} - {2'b00, divisor};
    qbit   = ~trial[WORD_BITS+1];
    // The remainder stays below the divisor, so it always fits a word.
    rem_next = qbit ? trial[WORD_BITS-1:0] : rem_sh[WORD_BITS-1:0];
    // Horner form: the sums end as q*mul_u and q*mul_v, wrapped to a word.
    acc_u_next = {acc_u[WORD_BITS-2:0], 1'b0} + (qbit ? mul_u : '0);
    acc_v_next = {acc_v[WORD_BITS-2:0], 1'b0} + (qbit ? mul_v : '0);
  end

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      dvd   <= dividend;
      rem   <= '0;
      acc_u <= '0;
      acc_v <= '0;
    end else if (ctl.step) begin
      dvd   <= {dvd[WORD_BITS-2:0], 1'b0};
      rem   <= rem_next;
      acc_u <= acc_u_next;
      acc_v <= acc_v_next;
    end
  end

endmodule

// File: rtl/lehmer_gcd_cofactor_step.sv
// ----------------------------------------------------------------------------
// lehmer_gcd_cofactor_step
// Runs single-word Euclid steps on two leading words and returns the
// cofactor matrix of the accepted steps for a double-digit GCD.
// ----------------------------------------------------------------------------
// Pulse start while busy is low to hand in one beat (lead_a, lead_b). The
// block then stays busy until it raises done for exactly one cycle with the
// four cofactors, negate and bad_input; the receiver cannot stall, so the
// result must be captured in that cycle. Every division attempt passes
// through a load, WORD_BITS quotient bits in the shared divide/accumulate
// unit, a state that forms the candidate cofactors and one that tests
// them; done follows the test of the last of n attempted divisions, where n
// counts the accepted steps plus the rejected one that ends the run, or just
// the accepted steps when the remainder reaches zero. A zero lead_b gives
// n = 0, so done is high in the cycle right after acceptance. Busy stays
// high through the done cycle and drops in the cycle after it, so the next
// beat can be accepted at the earliest at the edge that ends that idle cycle.
// ----------------------------------------------------------------------------
module lehmer_gcd_cofactor_step
  import lgcs_pkg::*;
#(
  parameter int WORD_BITS = 64
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [OUT_BITS-1:0] lead_a,
  input  logic [OUT_BITS-1:0] lead_b,
  output logic                done,
  output logic [OUT_BITS-1:0] coef_a_first,
  output logic [OUT_BITS-1:0] coef_b_first,
  output logic [OUT_BITS-1:0] coef_a_second,
  output logic [OUT_BITS-1:0] coef_b_second,
  output logic                negate,
  output logic                bad_input
);

  localparam int CNT_W = $clog2(WORD_BITS);

  // Sequencer states.
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_DIV  = 3'd2;
  localparam logic [2:0] ST_FORM = 3'd3;
  localparam logic [2:0] ST_TEST = 3'd4;
  localparam logic [2:0] ST_DONE = 3'd5;

  logic [2:0]           state;
  logic [2:0]           state_next;
  logic [CNT_W-1:0]     cnt;

  // Working pair of words and the running cofactor matrix.
  logic [WORD_BITS-1:0] a;
  logic [WORD_BITS-1:0] b;
  logic [WORD_BITS-1:0] u1;
  logic [WORD_BITS-1:0] u2;
  logic [WORD_BITS-1:0] v1;
  logic [WORD_BITS-1:0] v2;
  logic                 odd;
  logic                 bad;

  // Candidate values of the step under test.
  logic [WORD_BITS-1:0] u3;
  logic [WORD_BITS-1:0] v3;
  logic [WORD_BITS-1:0] diff;

  logic [WORD_BITS-1:0] rem;
  logic [WORD_BITS-1:0] acc_u;
  logic [WORD_BITS-1:0] acc_v;
  logic [WORD_BITS-1:0] bound;
  logic                 step_fail;
  logic                 accept;
  lgcs_ctl_t            ctl;

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign done   = (state == ST_DONE);

  assign ctl.load = (state == ST_LOAD);
  assign ctl.step = (state == ST_DIV);

  // The divide/accumulate unit delivers c = a mod b, q*u2 and q*v2 after
  // WORD_BITS steps; a, b, u2 and v2 stay put while it runs.
  lgcs_div_mac #(
    .WORD_BITS (WORD_BITS)
  ) u_div_mac (
    .clk      (clk),
    .ctl      (ctl),
    .dividend (a),
    .divisor  (b),
    .mul_u    (u2),
    .mul_v    (v2),
    .rem      (rem),
    .acc_u    (acc_u),
    .acc_v    (acc_v)
  );

  // A step is kept only while the remainder stays at or above the new
  // cofactor and the gap b - c covers the sum of the two B cofactors.
  assign bound     = v2 + v3;
  assign step_fail = (rem < v3) || (diff < bound);

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = (lead_b[WORD_BITS-1:0] == '0) ? ST_DONE : ST_LOAD;
        end
      end
      ST_LOAD: state_next = ST_DIV;
      ST_DIV: begin
        if (cnt == CNT_W'(WORD_BITS - 1)) begin
          state_next = ST_FORM;
        end
      end
      ST_FORM: state_next = ST_TEST;
      ST_TEST: begin
        // A zero remainder leaves nothing to divide by, so the run ends.
        if (step_fail || (rem == '0)) begin
          state_next = ST_DONE;
        end else begin
          state_next = ST_LOAD;
        end
      end
      ST_DONE: state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_DIV) begin
      cnt <= cnt + CNT_W'(1);
    end else begin
      cnt <= '0;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        if (accept) begin
          a   <= lead_a[WORD_BITS-1:0];
          b   <= lead_b[WORD_BITS-1:0];
          u1  <= WORD_BITS'(1);
          u2  <= '0;
          v1  <= '0;
          v2  <= WORD_BITS'(1);
          odd <= 1'b0;
          bad <= (lead_b[WORD_BITS-1:0] == '0);
        end
      end
      ST_FORM: begin
        u3   <= u1 + acc_u;
        v3   <= v1 + acc_v;
        diff <= b - rem;
      end
      ST_TEST: begin
        if (!step_fail) begin
          u1  <= u2;
          u2  <= u3;
          v1  <= v2;
          v2  <= v3;
          a   <= b;
          b   <= rem;
          odd <= ~odd;
        end
      end
      default: begin
      end
    endcase
  end

  // Results come straight from the matrix registers, widened to the ports.
  assign coef_a_first  = OUT_BITS'(u1);
  assign coef_b_first  = OUT_BITS'(v1);
  assign coef_a_second = OUT_BITS'(u2);
  assign coef_b_second = OUT_BITS'(v2);
  assign negate        = odd;
  assign bad_input     = bad;

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the single-word cofactor step block: a behavioral
// predictor of the Euclid run on the leading words forms the expected
// cofactor matrix of every accepted beat, and a monitor compares each done
// beat with the oldest outstanding expectation.
// ----------------------------------------------------------------------------
module tb_top
  import lgcs_pkg::*;
;

  // The block is built at its full word width, so no input bit is dropped.
  localparam int WORD_BITS = 64;
  localparam bit [OUT_BITS-1:0] WORD_MASK =
    (WORD_BITS >= OUT_BITS) ? {OUT_BITS{1'b1}} : ((64'd1 << WORD_BITS) - 64'd1);
  localparam bit [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

  // One result beat as the block presents it.
  typedef struct packed {
    bit [OUT_BITS-1:0] coef_a_first;
    bit [OUT_BITS-1:0] coef_b_first;
    bit [OUT_BITS-1:0] coef_a_second;
    bit [OUT_BITS-1:0] coef_b_second;
    bit                negate;
    bit                bad_input;
  } cofactor_t;

  // A pair of leading words for one input beat.
  typedef struct packed {
    bit [63:0] a;
    bit [63:0] b;
  } word_pair_t;

  logic                clk;
  logic                rst;
  logic                start;
  logic                busy;
  logic [OUT_BITS-1:0] lead_a;
  logic [OUT_BITS-1:0] lead_b;
  logic                done;
  logic [OUT_BITS-1:0] coef_a_first;
  logic [OUT_BITS-1:0] coef_b_first;
  logic [OUT_BITS-1:0] coef_a_second;
  logic [OUT_BITS-1:0] coef_b_second;
  logic                negate;
  logic                bad_input;

  // Matrices predicted for accepted beats, oldest first.
  cofactor_t pending_cofactors[$];
  int        fault_count = 0;

  lehmer_gcd_cofactor_step #(
    .WORD_BITS(WORD_BITS)
  ) dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .lead_a       (lead_a),
    .lead_b       (lead_b),
    .done         (done),
    .coef_a_first (coef_a_first),
    .coef_b_first (coef_b_first),
    .coef_a_second(coef_a_second),
    .coef_b_second(coef_b_second),
    .negate       (negate),
    .bad_input    (bad_input)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop. The slowest legal run is every beat taking the longest
  // Fibonacci-like chain of divisions (about 93 at 64 bits) plus the largest
  // sender gap; this bound is several times that.
  initial begin
    #600_000_000;
    $display("Simulation FAILED");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Predictor: Euclid steps on single words, starting from the identity
  // matrix, each candidate step kept only while the remainder stays at or
  // above the new B cofactor and the gap to the divisor stays at or above the
  // cofactor sum. Every sum and product wraps at the word width.
  // --------------------------------------------------------------------------
  function automatic cofactor_t predict_cofactor_step(bit [63:0] a_in, bit [63:0] b_in);
    bit [63:0] a, b, q, rem, u1, u2, v1, v2, u_next, v_next, gap, bound;
    bit        odd;
    bit        stop;
    cofactor_t res;
    a = a_in & WORD_MASK;
    b = b_in & WORD_MASK;
    u1 = 64'd1;
    u2 = 64'd0;
    v1 = 64'd0;
    v2 = 64'd1;
    odd = 1'b0;
    stop = 1'b0;
    if (b == 64'd0) begin
      // Zero divisor: identity matrix, flagged as bad input.
      res = '{64'd1, 64'd0, 64'd0, 64'd1, 1'b0, 1'b1};
      return res;
    end
    // A zero remainder after an accepted step ends the run as well.
    while (b != 64'd0 && !stop) begin
      q      = a / b;
      rem    = (a - q * b) & WORD_MASK;
      u_next = (u1 + q * u2) & WORD_MASK;
      v_next = (v1 + q * v2) & WORD_MASK;
      gap    = (b - rem) & WORD_MASK;
      bound  = (v2 + v_next) & WORD_MASK;
      if (rem < v_next || gap < bound) begin
        stop = 1'b1;
      end else begin
        u1  = u2;
        u2  = u_next;
        v1  = v2;
        v2  = v_next;
        a   = b;
        b   = rem;
        odd = ~odd;
      end
    end
    res = '{u1, v1, u2, v2, odd, 1'b0};
    return res;
  endfunction

  // --------------------------------------------------------------------------
  // Sender. Start stays high from the edge that raises it until a rising
  // edge sees it together with busy low; that edge accepts the beat. Both
  // start and busy are read in the active region right after the edge, so
  // they are the values the block itself saw. The caller either sends the
  // next beat at once (start stays high, one assignment in the step) or
  // lowers start through hold_start_low.
  // --------------------------------------------------------------------------
  task automatic send_beat(input bit [63:0] a, input bit [63:0] b);
    start  <= 1'b1;
    lead_a <= a;
    lead_b <= b;
    do @(posedge clk); while (busy);
    pending_cofactors.push_back(predict_cofactor_step(a, b));
  endtask

  task automatic hold_start_low(input int cycles);
    start <= 1'b0;
    repeat (cycles) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Monitor. Done marks a one-cycle result beat that cannot be held off; it
  // is taken at the edge that ends that cycle and set against the oldest
  // expectation, field by field.
  // --------------------------------------------------------------------------
  task automatic check_field(input string field, input bit [63:0] exp_val,
                             input bit [63:0] act_val);
    if (exp_val !== act_val) begin
      $display("%0t ns: %s mismatch: expected %h, actual %h", $time, field, exp_val, act_val);
      fault_count++;
    end
  endtask

  always @(posedge clk) begin
    cofactor_t exp_beat;
    if (!rst && done === 1'b1) begin
      if (pending_cofactors.size() == 0) begin
        $display("%0t ns: result beat with nothing outstanding: expected none, actual %h %h %h %h %b %b",
                 $time, coef_a_first, coef_b_first, coef_a_second, coef_b_second,
                 negate, bad_input);
        fault_count++;
      end else begin
        exp_beat = pending_cofactors.pop_front();
        check_field("coef_a_first", exp_beat.coef_a_first, coef_a_first);
        check_field("coef_b_first", exp_beat.coef_b_first, coef_b_first);
        check_field("coef_a_second", exp_beat.coef_a_second, coef_a_second);
        check_field("coef_b_second", exp_beat.coef_b_second, coef_b_second);
        check_field("negate", {63'd0, exp_beat.negate}, {63'd0, negate});
        check_field("bad_input", {63'd0, exp_beat.bad_input}, {63'd0, bad_input});
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers.
  // --------------------------------------------------------------------------
  function automatic bit [63:0] rand_word();
    return {$urandom, $urandom};
  endfunction

  // Builds a pair by running Euclid backwards from a small seed with mostly
  // small quotients, so the forward run takes many steps before the stop
  // test fires. Growth ends at word overflow or, now and then, earlier.
  function automatic word_pair_t deep_pair();
    bit [67:0]  prev, cur, nxt, q;
    bit         grow;
    word_pair_t p;
    prev = 68'($urandom_range(0, 3));
    cur  = prev + 68'd1 + 68'($urandom_range(0, 5));
    grow = 1'b1;
    while (grow) begin
      q   = ($urandom_range(0, 9) < 7) ? 68'd1 : 68'($urandom_range(2, 6));
      nxt = q * cur + prev;
      if (nxt[67:64] != 4'd0 || $urandom_range(0, 59) == 0) begin
        grow = 1'b0;
      end else begin
        prev = cur;
        cur  = nxt;
      end
    end
    p.a = cur[63:0];
    p.b = prev[63:0];
    return p;
  endfunction

  // One random pair of one of several kinds, among them pairs that keep the run going for many steps.
  function automatic word_pair_t random_pair();
    word_pair_t p;
    int         pick;
    pick = $urandom_range(0, 99);
    if (pick < 40) begin
      p.a = rand_word();
      p.b = rand_word();
    end else if (pick < 65) begin
      p = deep_pair();
    end else if (pick < 78) begin
      // Short words, so small quotients and tiny cofactors come up often.
      p.a = rand_word() >> $urandom_range(0, 63);
      p.b = rand_word() >> $urandom_range(0, 63);
    end else if (pick < 86) begin
      // Divisor just below the dividend.
      p.a = rand_word();
      p.b = p.a - (rand_word() >> $urandom_range(8, 63));
    end else if (pick < 93) begin
      // Deep pair handed in the wrong order: the first step is a swap.
      p   = deep_pair();
      p.a = p.a ^ p.b;
      p.b = p.a ^ p.b;
      p.a = p.a ^ p.b;
    end else if (pick < 97) begin
      p.a = rand_word();
      p.b = 64'd0;
    end else begin
      p.a = 64'd0;
      p.b = rand_word();
    end
    return p;
  endfunction

  // --------------------------------------------------------------------------
  // Directed tests.
  // --------------------------------------------------------------------------

  // A zero divisor must give the identity with bad_input set.
  task automatic test_zero_divisor();
    send_beat(64'd0, 64'd0);
    send_beat(ALL_ONES, 64'd0);
    hold_start_low($urandom_range(1, 13));
    send_beat(rand_word(), 64'd0);
  endtask

  // A zero dividend: one swap step is accepted and the remainder is zero.
  task automatic test_remainder_zero();
    send_beat(64'd0, ALL_ONES);
    send_beat(64'd0, 64'd1);
    send_beat(64'd0, rand_word() | 64'd1);
  endtask

  // The very first step fails the stop test, so the identity comes back.
  task automatic test_no_step();
    send_beat(ALL_ONES, 64'd1);
    send_beat(64'd12345, 64'd12345);
    send_beat(64'd1, 64'd1);
  endtask

  // Extremes and alternating bit patterns on both words.
  task automatic test_extremes();
    send_beat(ALL_ONES, ALL_ONES);
    send_beat(64'd1, ALL_ONES);
    send_beat(64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send_beat(64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send_beat(64'hAAAA_AAAA_AAAA_AAAA, 64'h5555_5555_5555_5555);
    hold_start_low($urandom_range(1, 13));
    send_beat(64'h5555_5555_5555_5555, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(ALL_ONES, 64'h8000_0000_0000_0001);
  endtask

  // Consecutive Fibonacci numbers, where all quotients are one and the run is longest, then two deep pairs.
  task automatic test_deep_runs();
    word_pair_t p;
    send_beat(64'd12200160415121876738, 64'd7540113804746346429);
    send_beat(64'd7540113804746346429, 64'd4660046610375530309);
    p = deep_pair();
    send_beat(p.a, p.b);
    p = deep_pair();
    send_beat(p.a, p.b);
  endtask

  // Random pairs. With gaps on, start drops for a random stretch after some
  // beats, which lands at varying points of the previous run.
  task automatic test_random_pairs(input int count, input bit with_gaps);
    word_pair_t p;
    for (int i = 0; i < count; i++) begin
      p = random_pair();
      send_beat(p.a, p.b);
      if (with_gaps && $urandom_range(0, 3) == 0) begin
        hold_start_low($urandom_range(1, 13));
      end
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence.
  // --------------------------------------------------------------------------
  initial begin
    int waited;
    rst    = 1'b1;
    start  = 1'b0;
    lead_a = '0;
    lead_b = '0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_zero_divisor();
    test_remainder_zero();
    test_no_step();
    test_extremes();
    test_deep_runs();
    test_random_pairs(1800, 1'b1);
    // Closing stretch with no idling on the sender side.
    test_random_pairs(200, 1'b0);
    hold_start_low(1);

    // Drain: wait for the outstanding result beats.
    waited = 0;
    while (pending_cofactors.size() != 0 && waited < 20000) begin
      @(posedge clk);
      waited++;
    end
    // Then keep watching to catch any stray done beat.
    repeat (200) @(posedge clk);
    if (pending_cofactors.size() != 0) begin
      $display("%0t ns: %0d expected result beats never arrived", $time,
               pending_cofactors.size());
      fault_count++;
    end

    if (fault_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
